[hw/rtl/mpsm_pkg.sv]
// Shared types and constants of the multi-pattern string matcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpsm_pkg;
  localparam int unsigned MaxNodes    = 1024;
  localparam int unsigned NodeW       = $clog2(MaxNodes);
  localparam int unsigned Alphabet    = 26;
  localparam int unsigned SymW        = 5;
  localparam int unsigned RowW        = Alphabet * NodeW;
  localparam int unsigned PatW        = 32;
  localparam int unsigned PidW        = 5;
  localparam int unsigned QPtrW       = NodeW + 1;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 80;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_SCAN  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_LOAD_LATE = 2'd2,
    ST_SCAN_EARLY = 2'd3
  } status_e;

  typedef struct packed {
    func_e            func;
    logic [SymW-1:0]  symbol;
    logic [PidW-1:0]  pattern_id;
    logic             pattern_end;
    logic             restart;
    logic             sym_ok;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } eng_status_t;
endpackage
`default_nettype wire

[hw/rtl/mpsm_front.sv]
// Front end: accepts input transfers, decodes them into commands and queues them.
// Depends on mpsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpsm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [mpsm_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output mpsm_pkg::cmd_t                cmd_o
);
  import mpsm_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.func        = func_e'(s_axis_tuser_i);
    dec.symbol      = s_axis_tdata_i[4:0];
    dec.pattern_id  = s_axis_tdata_i[9:5];
    dec.pattern_end = s_axis_tlast_i;
    dec.restart     = s_axis_tdata_i[10];
    dec.sym_ok      = ({1'b0, s_axis_tdata_i[4:0]} < 6'(Alphabet));
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

[hw/rtl/mpsm_engine.sv]
// Back end: trie memories, load/build/scan sequencer and result register.
// Depends on mpsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpsm_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  mpsm_pkg::cmd_t                 cmd_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [mpsm_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output mpsm_pkg::eng_status_t          status_o
);
  import mpsm_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LD_ROW = 4'd2;
  localparam logic [3:0] S_LD_TAG = 4'd3;
  localparam logic [3:0] S_SC_ROW = 4'd4;
  localparam logic [3:0] S_SC_SET = 4'd5;
  localparam logic [3:0] S_B_POP  = 4'd6;
  localparam logic [3:0] S_B_V    = 4'd7;
  localparam logic [3:0] S_B_U    = 4'd8;
  localparam logic [3:0] S_B_VRD  = 4'd9;
  localparam logic [3:0] S_B_MRG  = 4'd10;
  localparam logic [3:0] S_B_CH   = 4'd11;
  localparam logic [3:0] S_B_WR   = 4'd12;

  logic [RowW-1:0]  trans_mem [MaxNodes];
  logic [PatW-1:0]  mset_mem  [MaxNodes];
  logic [NodeW-1:0] slink_mem [MaxNodes];
  logic [NodeW-1:0] vq_mem    [MaxNodes];

  logic [RowW-1:0]  trans_rd_q, trans_wdata;
  logic [PatW-1:0]  mset_rd_q, mset_wdata;
  logic [NodeW-1:0] slink_rd_q, slink_wdata, vq_rd_q, vq_wdata;
  logic [NodeW-1:0] trans_raddr, trans_waddr, mset_raddr, mset_waddr;
  logic [NodeW-1:0] slink_raddr, slink_waddr, vq_raddr, vq_waddr;
  logic             trans_we, mset_we, slink_we, vq_we;

  logic [3:0]       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [NodeW-1:0] clr_q, clr_d, node_cnt_q, node_cnt_d, load_cur_q, load_cur_d;
  logic [NodeW-1:0] scan_cur_q, scan_cur_d, nxt_q, nxt_d, v_q, v_d;
  logic [PatW-1:0]  seen_q, seen_d, msu_q, msu_d;
  logic             built_q, built_d;
  logic [QPtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [RowW-1:0]  urow_q, urow_d, vrow_q, vrow_d;
  logic [SymW-1:0]  ch_q, ch_d;
  logic             out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic             res_fire;
  status_e          res_status;
  logic [PatW-1:0]  res_match;
  logic [NodeW-1:0] nxt_sel, child;
  logic [PatW-1:0]  pbit;

  always_ff @(posedge clk_i) begin
    if (trans_we) trans_mem[trans_waddr] <= trans_wdata;
    trans_rd_q <= trans_mem[trans_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (mset_we) mset_mem[mset_waddr] <= mset_wdata;
    mset_rd_q <= mset_mem[mset_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (slink_we) slink_mem[slink_waddr] <= slink_wdata;
    slink_rd_q <= slink_mem[slink_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (vq_we) vq_mem[vq_waddr] <= vq_wdata;
    vq_rd_q <= vq_mem[vq_raddr];
  end

  assign pbit = PatW'(1) << cmd_q.pattern_id;
  assign cmd_ready_o = (state_q == S_IDLE) && !out_valid_q;

  always_comb begin
    state_d = state_q;     cmd_d = cmd_q;       clr_d = clr_q;
    node_cnt_d = node_cnt_q; load_cur_d = load_cur_q; scan_cur_d = scan_cur_q;
    nxt_d = nxt_q; v_d = v_q; seen_d = seen_q; msu_d = msu_q;
    built_d = built_q; head_d = head_q; tail_d = tail_q;
    urow_d = urow_q; vrow_d = vrow_q; ch_d = ch_q;
    trans_we = 1'b0; trans_waddr = '0; trans_wdata = '0; trans_raddr = '0;
    mset_we = 1'b0;  mset_waddr = '0;  mset_wdata = '0;  mset_raddr = '0;
    slink_we = 1'b0; slink_waddr = '0; slink_wdata = '0; slink_raddr = '0;
    vq_we = 1'b0;    vq_waddr = '0;    vq_wdata = '0;    vq_raddr = '0;
    res_fire = 1'b0; res_status = ST_OK; res_match = '0;
    nxt_sel = trans_rd_q[cmd_q.symbol*NodeW +: NodeW];
    child   = vrow_q[ch_q*NodeW +: NodeW];

    unique case (state_q)
      S_CLEAR: begin
        trans_we = 1'b1; trans_waddr = clr_q;
        mset_we = 1'b1;  mset_waddr = clr_q;
        slink_we = 1'b1; slink_waddr = clr_q;
        clr_d = clr_q + NodeW'(1);
        if (clr_q == NodeW'(MaxNodes - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_d = cmd_i;
          unique case (cmd_i.func)
            FUNC_LOAD: begin
              if (built_q) begin
                res_fire = 1'b1; res_status = ST_LOAD_LATE;
              end else if (!cmd_i.sym_ok) begin
                res_fire = 1'b1;
              end else begin
                trans_raddr = load_cur_q;
                state_d = S_LD_ROW;
              end
            end
            FUNC_BUILD: begin
              if (built_q) begin
                res_fire = 1'b1;
              end else begin
                vq_we = 1'b1; vq_waddr = '0; vq_wdata = '0;
                head_d = '0; tail_d = QPtrW'(1);
                state_d = S_B_POP;
              end
            end
            FUNC_SCAN: begin
              if (!built_q) begin
                res_fire = 1'b1; res_status = ST_SCAN_EARLY;
              end else begin
                if (cmd_i.restart) begin
                  scan_cur_d = '0; seen_d = '0;
                end
                if (!cmd_i.sym_ok) begin
                  res_fire = 1'b1;
                end else begin
                  trans_raddr = cmd_i.restart ? '0 : scan_cur_q;
                  state_d = S_SC_ROW;
                end
              end
            end
            default: res_fire = 1'b1;
          endcase
        end
      end
      S_LD_ROW: begin
        if (nxt_sel == '0) begin
          if (node_cnt_q == NodeW'(MaxNodes - 1)) begin
            res_fire = 1'b1; res_status = ST_FULL;
          end else begin
            node_cnt_d = node_cnt_q + NodeW'(1);
            trans_we = 1'b1; trans_waddr = load_cur_q;
            trans_wdata = trans_rd_q;
            trans_wdata[cmd_q.symbol*NodeW +: NodeW] = node_cnt_d;
            nxt_d = node_cnt_d;
          end
        end else begin
          nxt_d = nxt_sel;
        end
        if (!res_fire) begin
          if (cmd_q.pattern_end) begin
            mset_raddr = nxt_d;
            state_d = S_LD_TAG;
          end else begin
            load_cur_d = nxt_d;
            res_fire = 1'b1;
          end
        end
      end
      S_LD_TAG: begin
        mset_we = 1'b1; mset_waddr = nxt_q; mset_wdata = mset_rd_q | pbit;
        load_cur_d = '0;
        res_fire = 1'b1;
      end
      S_SC_ROW: begin
        scan_cur_d = nxt_sel;
        mset_raddr = nxt_sel;
        state_d = S_SC_SET;
      end
      S_SC_SET: begin
        res_match = mset_rd_q;
        seen_d = seen_q | mset_rd_q;
        res_fire = 1'b1;
      end
      S_B_POP: begin
        if (head_q < tail_q) begin
          vq_raddr = head_q[NodeW-1:0];
          state_d = S_B_V;
        end else begin
          built_d = 1'b1;
          res_fire = 1'b1;
        end
      end
      S_B_V: begin
        v_d = vq_rd_q;
        head_d = head_q + QPtrW'(1);
        slink_raddr = vq_rd_q;
        state_d = S_B_U;
      end
      S_B_U: begin
        trans_raddr = slink_rd_q;
        mset_raddr = slink_rd_q;
        state_d = S_B_VRD;
      end
      S_B_VRD: begin
        urow_d = trans_rd_q;
        msu_d = mset_rd_q;
        trans_raddr = v_q;
        mset_raddr = v_q;
        state_d = S_B_MRG;
      end
      S_B_MRG: begin
        vrow_d = trans_rd_q;
        mset_we = 1'b1; mset_waddr = v_q; mset_wdata = mset_rd_q | msu_q;
        ch_d = '0;
        state_d = S_B_CH;
      end
      S_B_CH: begin
        if (child != '0) begin
          slink_we = 1'b1; slink_waddr = child;
          slink_wdata = (v_q == '0) ? '0 : urow_q[ch_q*NodeW +: NodeW];
          if (tail_q < QPtrW'(MaxNodes)) begin
            vq_we = 1'b1; vq_waddr = tail_q[NodeW-1:0]; vq_wdata = child;
            tail_d = tail_q + QPtrW'(1);
          end
        end else begin
          vrow_d[ch_q*NodeW +: NodeW] = urow_q[ch_q*NodeW +: NodeW];
        end
        if (ch_q == SymW'(Alphabet - 1)) state_d = S_B_WR;
        else ch_d = ch_q + SymW'(1);
      end
      S_B_WR: begin
        trans_we = 1'b1; trans_waddr = v_q; trans_wdata = vrow_q;
        state_d = S_B_POP;
      end
      default: state_d = S_IDLE;
    endcase

    if (res_fire) state_d = S_IDLE;
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    if (res_fire) begin
      out_valid_d = 1'b1;
      out_data_d = {4'd0, node_cnt_d, seen_d, res_match, res_status};
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; nxt_q <= nxt_d; v_q <= v_d; msu_q <= msu_d;
    urow_q <= urow_d; vrow_q <= vrow_d; ch_q <= ch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; node_cnt_q <= '0; load_cur_q <= '0;
      scan_cur_q <= '0; seen_q <= '0; built_q <= 1'b0;
      head_q <= '0; tail_q <= '0; out_valid_q <= 1'b0; out_data_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; node_cnt_q <= node_cnt_d;
      load_cur_q <= load_cur_d; scan_cur_q <= scan_cur_d; seen_q <= seen_d;
      built_q <= built_d; head_q <= head_d; tail_q <= tail_d;
      out_valid_q <= out_valid_d; out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign status_o.clearing = (state_q == S_CLEAR);
  assign status_o.busy     = (state_q != S_IDLE);
endmodule
`default_nettype wire

[hw/rtl/multi_pattern_string_matcher.sv]
// Top level of the multi-pattern string matcher: front decoder/queue and engine.
// Depends on mpsm_pkg, mpsm_front, mpsm_engine.
//
// channel  dir  fields
// s_axis   in   tuser: func; tlast: pattern_end; tdata: symbol, pattern_id, restart
// m_axis   out  tdata: status, match_mask, seen_mask, nodes_used
//
// Scan and load take their result from the registered read of the transition and
// match-set memories. Build handles one trie node at a time. After reset a clearing
// pass zeroes the transition, match-set and link memories; input is queued but not
// executed meanwhile. Output stalls hold the result and block the engine.
`timescale 1ns / 1ps
`default_nettype none
module multi_pattern_string_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // symbol[4:0], pattern_id[9:5], restart[10]
  input  logic        s_axis_tlast,   // pattern_end
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // status[1:0], match_mask[33:2],
                                      // seen_mask[65:34], nodes_used[75:66]
);
  import mpsm_pkg::*;

  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  eng_status_t eng_st;

  mpsm_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .s_axis_tuser_i  (s_axis_tuser),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  mpsm_engine u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .status_o        (eng_st)
  );

`ifndef NO_ASSERTIONS
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_st.clearing |-> !m_axis_tvalid) else $error("result during clearing pass");
  a_nodes_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> m_axis_tdata[75:66] >= $past(m_axis_tdata[75:66]))
    else $error("nodes_used decreased");
  a_no_pop_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_st.busy |-> !cmd_ready) else $error("command taken while engine busy");
`endif
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking bench for multi_pattern_string_matcher: dictionary load, link build, text scan.
// Depends on mpsm_pkg and the matcher RTL; a scoreboard class holds the trie mirror.
`timescale 1ns / 1ps

import mpsm_pkg::*;

typedef struct {
  func_e      func;
  logic [4:0] symbol;
  logic [4:0] pattern_id;
  logic       pattern_end;
  logic       restart;
} cmd_item_t;

typedef struct {
  logic [1:0]  status;
  logic [31:0] match_mask;
  logic [31:0] seen_mask;
  logic [9:0]  nodes_used;
} match_result_t;

class match_scoreboard;
  logic [9:0]  goto_tbl [MaxNodes*Alphabet];
  logic [31:0] out_set [MaxNodes];
  logic [9:0]  fail_link [MaxNodes];
  int unsigned node_cnt, load_node, scan_node;
  logic [31:0] seen;
  bit          built;
  match_result_t pending[$];
  int errors, n_loads, n_scans, n_hits, n_full;

  function new();
    foreach (goto_tbl[i]) goto_tbl[i] = '0;
    foreach (out_set[i]) out_set[i] = '0;
    foreach (fail_link[i]) fail_link[i] = '0;
    node_cnt = 0; load_node = 0; scan_node = 0; seen = '0; built = 0;
    errors = 0; n_loads = 0; n_scans = 0; n_hits = 0; n_full = 0;
  endfunction

  function void build_links();
    int unsigned order[$];
    int unsigned v, u, child;
    int head;
    head = 0;
    order.push_back(0);
    while (head < order.size() && head < MaxNodes) begin
      v = order[head];
      head++;
      u = fail_link[v];
      out_set[v] |= out_set[u];
      for (int c = 0; c < Alphabet; c++) begin
        child = goto_tbl[v*Alphabet + c];
        if (child != 0) begin
          fail_link[child] = (v == 0) ? 10'd0 : goto_tbl[u*Alphabet + c];
          if (order.size() < MaxNodes) order.push_back(child);
        end else begin
          goto_tbl[v*Alphabet + c] = goto_tbl[u*Alphabet + c];
        end
      end
    end
    built = 1;
  endfunction

  function logic [1:0] load_symbol(cmd_item_t c);
    int unsigned nxt;
    if (built) return ST_LOAD_LATE;
    if (c.symbol >= Alphabet) return ST_OK;
    nxt = goto_tbl[load_node*Alphabet + c.symbol];
    if (nxt == 0) begin
      if (node_cnt + 1 >= MaxNodes) return ST_FULL;
      node_cnt++;
      nxt = node_cnt;
      goto_tbl[load_node*Alphabet + c.symbol] = nxt[9:0];
    end
    if (c.pattern_end) begin
      out_set[nxt] |= 32'd1 << c.pattern_id;
      nxt = 0;
    end
    load_node = nxt;
    return ST_OK;
  endfunction

  function void note_input(cmd_item_t c);
    match_result_t r;
    r.status = ST_OK;
    r.match_mask = '0;
    case (c.func)
      FUNC_LOAD: begin
        n_loads++;
        r.status = load_symbol(c);
        if (r.status == ST_FULL) n_full++;
      end
      FUNC_BUILD: if (!built) build_links();
      FUNC_SCAN: begin
        if (!built) begin
          r.status = ST_SCAN_EARLY;
        end else begin
          n_scans++;
          if (c.restart) begin
            scan_node = 0;
            seen = '0;
          end
          if (c.symbol < Alphabet) begin
            scan_node = goto_tbl[scan_node*Alphabet + c.symbol];
            r.match_mask = out_set[scan_node];
            seen |= r.match_mask;
            if (r.match_mask != 0) n_hits++;
          end
        end
      end
      default: ;
    endcase
    r.seen_mask = seen;
    r.nodes_used = node_cnt[9:0];
    pending.push_back(r);
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [79:0] d);
    match_result_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result %h", d));
      return;
    end
    e = pending.pop_front();
    if (d[1:0] !== e.status)
      report($sformatf("status %0d, want %0d", d[1:0], e.status));
    if (d[33:2] !== e.match_mask)
      report($sformatf("match_mask %h, want %h", d[33:2], e.match_mask));
    if (d[65:34] !== e.seen_mask)
      report($sformatf("seen_mask %h, want %h", d[65:34], e.seen_mask));
    if (d[75:66] !== e.nodes_used)
      report($sformatf("nodes_used %0d, want %0d", d[75:66], e.nodes_used));
  endtask
endclass

module tb;
  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;

  match_scoreboard sb;
  int  items_sent;
  int  send_idle, recv_idle;
  bit  hold_go;
  int  hold_left;

  multi_pattern_string_matcher u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic set_idling();
    if (items_sent < 600) begin
      send_idle = 30; recv_idle = 47;
    end else if (items_sent < 1200) begin
      send_idle = 47; recv_idle = 30;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  endtask

  task automatic send(cmd_item_t c);
    set_idling();
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.func;
    s_axis_tlast  <= c.pattern_end;
    s_axis_tdata  <= {5'd0, c.restart, c.pattern_id, c.symbol};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(c);
    items_sent++;
  endtask

  task automatic send_cmd(func_e f, int sym, int pid, bit pend, bit rs);
    cmd_item_t c;
    c.func = f;
    c.symbol = sym[4:0];
    c.pattern_id = pid[4:0];
    c.pattern_end = pend;
    c.restart = rs;
    send(c);
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: send_cmd(FUNC_NONE, $urandom_range(31), $urandom_range(31), $urandom_range(1),
                  $urandom_range(1));
      1: send_cmd(FUNC_LOAD, $urandom_range(26, 31), $urandom_range(31), $urandom_range(1),
                  $urandom_range(1));
      default: send_cmd(FUNC_SCAN, $urandom_range(26, 31), $urandom_range(31),
                        $urandom_range(1), $urandom_range(1));
    endcase
  endtask

  task automatic load_word(int len, int max_sym, int pid);
    for (int i = 0; i < len; i++)
      send_cmd(FUNC_LOAD, $urandom_range(max_sym), pid, i == len - 1, $urandom_range(1));
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    hold_go = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    s_axis_tuser = FUNC_NONE;
    m_axis_tready = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(FUNC_NONE, 31, 31, 1, 1);
    send_cmd(FUNC_SCAN, 0, 0, 0, 1);
    send_cmd(FUNC_SCAN, 25, 31, 1, 0);
    send_cmd(FUNC_LOAD, 31, 7, 1, 0);
    send_cmd(FUNC_LOAD, 26, 7, 0, 0);
    send_cmd(FUNC_LOAD, 0, 0, 1, 0);
    send_cmd(FUNC_LOAD, 0, 31, 0, 0);
    send_cmd(FUNC_LOAD, 1, 31, 1, 1);
    send_cmd(FUNC_LOAD, 1, 16, 1, 0);
    send_cmd(FUNC_LOAD, 25, 15, 0, 0);
    send_cmd(FUNC_LOAD, 25, 15, 1, 0);
    send_cmd(FUNC_LOAD, 0, 3, 0, 0);
    send_cmd(FUNC_LOAD, 1, 3, 1, 0);

    for (int p = 0; p < 60; p++) begin
      if ($urandom_range(9) == 0) send_noise();
      load_word($urandom_range(1, 5), 3, $urandom_range(31));
    end
    while (sb.node_cnt < MaxNodes - 1) begin
      if ($urandom_range(19) == 0) send_noise();
      send_cmd(FUNC_LOAD, $urandom_range(25), $urandom_range(31), $urandom_range(24) == 0,
               $urandom_range(1));
    end
    for (int i = 0; i < 6; i++)
      send_cmd(FUNC_LOAD, $urandom_range(25), $urandom_range(31), $urandom_range(1), 0);

    send_cmd(FUNC_BUILD, 0, 0, 0, 0);
    send_cmd(FUNC_BUILD, 31, 31, 1, 1);
    send_cmd(FUNC_LOAD, 0, 0, 1, 0);
    send_cmd(FUNC_LOAD, 31, 31, 0, 0);
    send_cmd(FUNC_SCAN, 31, 0, 0, 1);
    send_cmd(FUNC_SCAN, 25, 0, 0, 0);
    send_cmd(FUNC_SCAN, 0, 0, 0, 1);

    hold_go = 1;
    while (items_sent < 1750) begin
      if ($urandom_range(19) == 0) send_noise();
      else if ($urandom_range(49) == 0) send_cmd(FUNC_LOAD, $urandom_range(31),
                                                 $urandom_range(31), $urandom_range(1), 0);
      else send_cmd(FUNC_SCAN, ($urandom_range(9) == 0) ? $urandom_range(25) : $urandom_range(3),
                    $urandom_range(31), $urandom_range(1), $urandom_range(29) == 0);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d loads (%0d table-full), %0d scans after build, %0d with matches",
             sb.n_loads, sb.n_full, sb.n_scans, sb.n_hits);
    $display("trie reached %0d nodes, %0d transfers in total", sb.node_cnt, items_sent);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
